// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker wsd_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define WSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the clock cycle after the antecedent.
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wsd_pkg.sv
// Types and constants of the websocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned PayLenW = 64;
  localparam int unsigned TdataW  = 80;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    PH_B0   = 3'd0,
    PH_B1   = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_HDR_END = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  // One result word as it leaves the parser.
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           out_byte;
    logic                 fin_flag;
    logic [3:0]           opcode;
    logic                 masked_flag;
    logic [PayLenW-1:0]   payload_length;
    logic                 frame_end;
  } wsd_result_t;

endpackage

// File: rtl/core/wsd_parser.sv
// Frame header parser and payload unmasking: state registers and per-word logic.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          in_byte_i,
  input  logic                restart_i,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            key_q, key_d;
  logic [LENGTH_BITS-1:0] idx_q, idx_d;
  logic                   fin_q, fin_d;
  logic [3:0]             op_q, op_d;
  logic                   msk_q, msk_d;

  phase_e                 ph;
  logic                   done;
  logic [LENGTH_BITS-1:0] final_len;
  logic [LENGTH_BITS-1:0] shifted;
  logic                   ovf_n;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS-1:0] idx_inc;

  // Next state and result for the word at the input register
  always_comb begin
    ph        = restart_i ? PH_B0 : phase_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    key_d     = key_q;
    idx_d     = idx_q;
    fin_d     = fin_q;
    op_d      = op_q;
    msk_d     = msk_q;
    done      = 1'b0;
    final_len = len_q;
    shifted   = {len_q[LENGTH_BITS-9:0], in_byte_i};
    ovf_n     = ovf_q | (|len_q[LENGTH_BITS-1 -: 8]);
    idx_inc   = idx_q + LENGTH_BITS'(1);
    key_byte  = 8'h00;

    res_o.kind           = KIND_HDR;
    res_o.out_byte       = 8'h00;
    res_o.payload_length = '0;
    res_o.frame_end      = 1'b0;

    unique case (idx_q[1:0])
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      2'd3: key_byte = key_q[7:0];
      default: key_byte = 8'h00;
    endcase

    unique case (ph)
      PH_B1: begin
        msk_d = in_byte_i[7];
        key_d = '0;
        if (in_byte_i[6:0] == Len7Ext16) begin
          len_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = Ext16Bytes;
          phase_d = PH_EXT;
        end else if (in_byte_i[6:0] == Len7Ext64) begin
          len_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = Ext64Bytes;
          phase_d = PH_EXT;
        end else begin
          len_d = LENGTH_BITS'(in_byte_i[6:0]);
          if (in_byte_i[7]) begin
            cnt_d   = KeyBytes;
            phase_d = PH_MASK;
          end else begin
            done      = 1'b1;
            final_len = LENGTH_BITS'(in_byte_i[6:0]);
          end
        end
      end
      PH_EXT: begin
        len_d = shifted;
        ovf_d = ovf_n;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          if (msk_q) begin
            cnt_d   = KeyBytes;
            phase_d = PH_MASK;
          end else begin
            done      = 1'b1;
            final_len = ovf_n ? '1 : shifted;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], in_byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          done      = 1'b1;
          final_len = ovf_q ? '1 : len_q;
        end
      end
      PH_PAY: begin
        res_o.kind           = KIND_PAYLOAD;
        res_o.out_byte       = in_byte_i ^ (msk_q ? key_byte : 8'h00);
        res_o.payload_length = PayLenW'(len_q);
        idx_d                = idx_inc;
        // index stays below the length, so reaching it ends the frame
        if (idx_inc == len_q) begin
          res_o.frame_end = 1'b1;
          phase_d         = PH_B0;
        end
      end
      default: begin
        fin_d   = in_byte_i[7];
        op_d    = in_byte_i[3:0];
        msk_d   = 1'b0;
        cnt_d   = '0;
        len_d   = '0;
        ovf_d   = 1'b0;
        key_d   = '0;
        idx_d   = '0;
        phase_d = PH_B1;
      end
    endcase

    // Header complete: latch the saturated length and pick the next phase
    if (done) begin
      len_d                = final_len;
      ovf_d                = 1'b0;
      idx_d                = '0;
      res_o.kind           = KIND_HDR_END;
      res_o.payload_length = PayLenW'(final_len);
      if (final_len == '0) begin
        res_o.frame_end = 1'b1;
        phase_d         = PH_B0;
      end else begin
        phase_d = PH_PAY;
      end
    end

    res_o.fin_flag    = fin_d;
    res_o.opcode      = op_d;
    res_o.masked_flag = msk_d;
  end

  // Parser state, advanced once per word moved to the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_B0;
      cnt_q   <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      key_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      op_q    <= '0;
      msk_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      msk_q   <= msk_d;
    end
  end

endmodule

// File: rtl/core/wsd_out_stage.sv
// Output register holding one result word until the sink takes it.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  wsd_pkg::wsd_result_t res_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  logic        valid_q;
  wsd_result_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side: splits a byte stream into frame headers
// and unmasked payload. A parameter sets the width of the payload length counter.
// Usage:
//   Slave side: one received byte per word in s_axis_tdata_i; s_axis_tuser_i set
//   marks a byte that starts a new frame header and abandons the current frame.
//   Master side: exactly one result word per input word, in order. tuser gives
//   the kind (header byte, last header byte, payload byte), tlast marks the last
//   word of a frame (a zero-length frame ends on its last header byte), and tdata
//   carries the unmasked byte, FIN, opcode, mask bit and payload length.
//   Path: an accepted word sits in the input register, is parsed by combinational
//   logic and is registered in the output register, from which it is offered.
//   Throughput: one word per cycle while the sink holds tready high; parsing is
//   one pass of logic between the input register and the output register.
//   Reset: both registers empty, parser waits for the first byte of a header.
//   Stall: when the sink holds tready low the output word stays put; at most one more
//   word is taken into the input register, then s_axis_tready_o falls.
//   A length larger than LENGTH_BITS bits saturates to all ones.
`timescale 1ns / 1ps

module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,  // [7:0] in_byte
  input  logic [0:0]                 s_axis_tuser_i,  // [0] restart
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] out_byte, [8] fin_flag, [12:9] opcode, [13] masked_flag,
  // [77:14] payload_length, [79:78] zero
  output logic [wsd_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic [1:0]                 m_axis_tuser_o,  // [1:0] kind
  output logic                       m_axis_tlast_o   // frame_end
);
  import wsd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_restart_q;
  logic        out_ready;
  logic        step;
  wsd_result_t res;
  wsd_result_t out_res;

  assign step            = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i[0];
    end
  end

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_byte_i (in_byte_q),
    .restart_i (in_restart_q),
    .res_o     (res)
  );

  wsd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (out_ready),
    .res_i   (res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  // Pack the result word onto the master side
  assign m_axis_tdata_o = {2'b00, out_res.payload_length, out_res.masked_flag,
                           out_res.opcode, out_res.fin_flag, out_res.out_byte};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.frame_end;

endmodule

// File: rtl/core/wsd_checker.sv
// Port-level checks for the websocket frame deframer, bound to the top level.
// Depends on wsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [wsd_pkg::TdataW-1:0] m_axis_tdata_o,
  input logic [1:0]                 m_axis_tuser_o,
  input logic                       m_axis_tlast_o
);
  import wsd_pkg::*;

  // A stalled result word stays offered
  `WSD_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")

  // With the output side empty the input side takes a word
  `WSD_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o, "input stalled with empty output")

  // Header words never carry a data byte
  `WSD_ASSERT_IMPL(a_hdr_zero_byte, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_PAYLOAD), m_axis_tdata_o[7:0] == 8'h00, "header word with nonzero byte")

  // A frame never ends, and no length is given, on a header byte before the last one
  `WSD_ASSERT_IMPL(a_no_mid_hdr_end, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == KIND_HDR), !m_axis_tlast_o && (m_axis_tdata_o[77:14] == '0), "frame end or length on early header byte")

  // Zero-length frame ends on the last header byte
  `WSD_ASSERT_IMPL(a_zero_len_end, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == KIND_HDR_END) && (m_axis_tdata_o[77:14] == '0), m_axis_tlast_o, "empty frame not closed at header end")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

// File: verif/websocket_frame_deframer_checker.sv
// Checker for the websocket frame deframer: follows both stream channels,
// parses every accepted byte the way the block should, and compares result words.
// Depends on wsd_pkg for the result word type, kind codes and header constants.
`timescale 1ns / 1ps

module websocket_frame_deframer_checker #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  input  logic [7:0]                 s_axis_tdata_i,   // [7:0] in_byte
  input  logic [0:0]                 s_axis_tuser_i,   // [0] restart
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  // [7:0] out_byte, [8] fin_flag, [12:9] opcode, [13] masked_flag,
  // [77:14] payload_length, [79:78] zero
  input  logic [wsd_pkg::TdataW-1:0] m_axis_tdata_i,
  input  logic [1:0]                 m_axis_tuser_i,   // [1:0] kind
  input  logic                       m_axis_tlast_i,   // frame_end
  output int                         mismatch_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  import wsd_pkg::*;

  // Parser state as the block should hold it
  phase_e      ph_q;
  logic [3:0]  hdr_left_q;
  logic [63:0] len_q;
  logic [31:0] key_q;
  logic [63:0] idx_q;
  logic        fin_q;
  logic        masked_q;
  logic [3:0]  opc_q;

  wsd_result_t expected_words[$];
  int          n_bad;
  int          n_checked;

  // Clamp a decoded length to what the length counter can hold
  function automatic logic [63:0] clamp_length(input logic [63:0] v);
    logic [63:0] top;
    if (LENGTH_BITS >= 64) begin
      return v;
    end
    top = (64'd1 << LENGTH_BITS) - 64'd1;
    return (v > top) ? top : v;
  endfunction

  // Header complete: fix the length, choose payload or next frame
  task automatic close_header(inout wsd_result_t r);
    len_q = clamp_length(len_q);
    idx_q = '0;
    r.kind = KIND_HDR_END;
    r.payload_length = len_q;
    if (len_q == '0) begin
      r.frame_end = 1'b1;
      ph_q = PH_B0;
    end else begin
      ph_q = PH_PAY;
    end
  endtask

  // Advance the parser by one received byte, give the result word it causes
  task automatic parse_byte(input logic [7:0] b, input logic restart,
                            output wsd_result_t r);
    phase_e     ph;
    logic [6:0] len7;
    logic [7:0] k;
    r  = '0;
    ph = restart ? PH_B0 : ph_q;
    case (ph)
      PH_B1: begin
        len7     = b[6:0];
        masked_q = b[7];
        key_q    = '0;
        if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
          len_q      = '0;
          hdr_left_q = (len7 == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
          ph_q       = PH_EXT;
        end else begin
          len_q = 64'(len7);
          if (masked_q) begin
            hdr_left_q = KeyBytes;
            ph_q       = PH_MASK;
          end else begin
            close_header(r);
          end
        end
      end
      PH_EXT: begin
        len_q      = {len_q[55:0], b};
        hdr_left_q = hdr_left_q - 4'd1;
        if (hdr_left_q == '0) begin
          if (masked_q) begin
            hdr_left_q = KeyBytes;
            ph_q       = PH_MASK;
          end else begin
            close_header(r);
          end
        end
      end
      PH_MASK: begin
        key_q      = {key_q[23:0], b};
        hdr_left_q = hdr_left_q - 4'd1;
        if (hdr_left_q == '0) close_header(r);
      end
      PH_PAY: begin
        // first key byte sits in the top bits
        k = b;
        if (masked_q) k = k ^ key_q[8*(3 - idx_q[1:0]) +: 8];
        r.kind           = KIND_PAYLOAD;
        r.out_byte       = k;
        r.payload_length = len_q;
        idx_q            = idx_q + 64'd1;
        if (idx_q >= len_q) begin
          r.frame_end = 1'b1;
          ph_q        = PH_B0;
        end
      end
      default: begin
        // first header byte, also taken on restart
        fin_q      = b[7];
        opc_q      = b[3:0];
        masked_q   = 1'b0;
        hdr_left_q = '0;
        len_q      = '0;
        key_q      = '0;
        idx_q      = '0;
        ph_q       = PH_B1;
      end
    endcase
    r.fin_flag    = fin_q;
    r.opcode      = opc_q;
    r.masked_flag = masked_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wsd_result_t got;
    wsd_result_t want;
    if (!rst_ni) begin
      ph_q       = PH_B0;
      hdr_left_q = '0;
      len_q      = '0;
      key_q      = '0;
      idx_q      = '0;
      fin_q      = 1'b0;
      masked_q   = 1'b0;
      opc_q      = '0;
      n_bad      = 0;
      n_checked  = 0;
      expected_words.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      // outgoing word first: it always stems from an earlier input
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind           = kind_e'(m_axis_tuser_i);
        got.out_byte       = m_axis_tdata_i[7:0];
        got.fin_flag       = m_axis_tdata_i[8];
        got.opcode         = m_axis_tdata_i[12:9];
        got.masked_flag    = m_axis_tdata_i[13];
        got.payload_length = m_axis_tdata_i[77:14];
        got.frame_end      = m_axis_tlast_i;
        if (expected_words.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] result word with nothing pending: kind=%0d byte=%02h end=%0d",
                     $realtime, got.kind, got.out_byte, got.frame_end);
        end else begin
          want = expected_words.pop_front();
          n_checked++;
          if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
              got.fin_flag !== want.fin_flag || got.opcode !== want.opcode ||
              got.masked_flag !== want.masked_flag ||
              got.payload_length !== want.payload_length ||
              got.frame_end !== want.frame_end) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("[%0t] word %0d mismatch", $realtime, n_checked);
              $display("  exp kind=%0d byte=%02h fin=%0d op=%0h mask=%0d len=%016h end=%0d",
                       want.kind, want.out_byte, want.fin_flag, want.opcode,
                       want.masked_flag, want.payload_length, want.frame_end);
              $display("  got kind=%0d byte=%02h fin=%0d op=%0h mask=%0d len=%016h end=%0d",
                       got.kind, got.out_byte, got.fin_flag, got.opcode,
                       got.masked_flag, got.payload_length, got.frame_end);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_byte(s_axis_tdata_i, s_axis_tuser_i[0], want);
        expected_words.push_back(want);
      end
      mismatch_count_o <= n_bad;
      pending_o        <= expected_words.size();
      checked_o        <= n_checked;
    end
  end

endmodule

// File: verif/websocket_frame_deframer_tb.sv
// Testbench top for the websocket frame deframer: drives a byte stream of
// well-formed, truncated and noisy frames with random stalls on both sides.
// Depends on wsd_pkg, the deframer RTL and websocket_frame_deframer_checker.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int unsigned LenBits    = 64;
  localparam int          RandBytes  = 1250;
  localparam int          HoldCycles = 200;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;
  logic [0:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [TdataW-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;

  int mismatches;
  int pending;
  int checked;

  // Traffic bookkeeping
  int   bytes_sent   = 0;
  int   restarts     = 0;
  int   frames       = 0;
  int   masked_n     = 0;
  int   zero_len_n   = 0;
  int   cut_n        = 0;
  int   noise_n      = 0;
  logic need_restart = 1'b0;
  logic calm_tx      = 1'b0;
  logic calm_rx      = 1'b0;
  logic hold_req     = 1'b0;

  websocket_frame_deframer #(
    .LENGTH_BITS(LenBits)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  websocket_frame_deframer_checker #(
    .LENGTH_BITS(LenBits)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .m_axis_tlast_i   (m_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one byte after a random gap; returns at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (restart) restarts++;
  endtask

  // One frame with random header form; some are cut short
  task automatic send_frame();
    logic [7:0]  hdr[$];
    logic        fin;
    logic        masked;
    logic [2:0]  rsv;
    logic [3:0]  opc;
    logic [63:0] len;
    logic [31:0] key;
    logic        huge;
    logic        cut;
    logic        first_r;
    logic [7:0]  pb;
    int          form;
    int          pay_n;
    int          total;
    fin    = 1'($urandom);
    rsv    = 3'($urandom);
    opc    = 4'($urandom);
    masked = ($urandom_range(0, 3) != 0);
    key    = $urandom;
    huge   = 1'b0;
    form   = $urandom_range(0, 99);
    hdr.push_back({fin, rsv, opc});
    if (form < 55) begin
      if ($urandom_range(0, 7) == 0) len = '0;
      else if ($urandom_range(0, 19) == 0) len = 64'($urandom_range(21, 125));
      else len = 64'($urandom_range(1, 20));
      hdr.push_back({masked, len[6:0]});
    end else if (form < 85) begin
      if ($urandom_range(0, 9) == 0) len = 64'($urandom_range(126, 300));
      else len = 64'($urandom_range(0, 40));
      if ($urandom_range(0, 19) == 0) begin
        len  = 64'($urandom_range(0, 65535));
        huge = 1'b1;
      end
      hdr.push_back({masked, Len7Ext16});
      hdr.push_back(len[15:8]);
      hdr.push_back(len[7:0]);
    end else begin
      len = 64'($urandom_range(0, 40));
      if ($urandom_range(0, 4) == 0) begin
        len  = {$urandom, $urandom};
        huge = 1'b1;
      end
      hdr.push_back({masked, Len7Ext64});
      for (int i = 7; i >= 0; i--) hdr.push_back(len[8*i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) hdr.push_back(key[8*i +: 8]);
    end
    // huge lengths only ever get a few payload bytes before the next restart
    pay_n = huge ? $urandom_range(0, 8) : int'(len);
    total = hdr.size() + pay_n;
    cut   = huge || ($urandom_range(0, 7) == 0);
    if (cut && !huge) total = $urandom_range(1, total);
    first_r      = need_restart ? 1'b1 : 1'($urandom);
    need_restart = cut;
    for (int i = 0; i < total; i++) begin
      pb = (i < hdr.size()) ? hdr[i] : 8'($urandom);
      send_byte(pb, (i == 0) ? first_r : 1'b0);
    end
    frames++;
    if (masked) masked_n++;
    if (cut) cut_n++;
    else if (len == '0) zero_len_n++;
  endtask

  // Receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      n = calm_rx ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 29) == 0) calm_rx = !calm_rx;
    end
  end

  // Stimulus and verdict
  initial begin
    // {restart, byte}: zero-length masked frame, short unmasked frame,
    // masked frame abandoned mid payload, 64-bit length abandoned in the
    // extension, zero-length frame through the 16-bit extension
    logic [8:0] directed [26] = '{
      {1'b1, 8'hFF}, {1'b0, 8'h80}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h55},
      {1'b0, 8'hAA},
      {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h00}, {1'b0, 8'hFF},
      {1'b0, 8'h81}, {1'b0, 8'h85}, {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b0, 8'h56},
      {1'b0, 8'h78}, {1'b0, 8'hC3}, {1'b0, 8'h3C},
      {1'b1, 8'h09}, {1'b0, 8'h7F}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
      {1'b1, 8'h88}, {1'b0, 8'h7E}, {1'b0, 8'h00}, {1'b0, 8'h00}
    };
    logic hold_asked;
    logic drained;
    int   target;
    hold_asked = 1'b0;
    drained    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    target = bytes_sent + RandBytes;

    while (bytes_sent < target) begin
      if (!hold_asked && bytes_sent >= 400) begin
        hold_req   = 1'b1;
        hold_asked = 1'b1;
      end
      // source pause until the block has handed out everything
      if (!drained && bytes_sent >= 800) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) calm_tx = !calm_tx;
      if ($urandom_range(0, 19) == 0) begin
        // burst of garbage with scattered restarts
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        need_restart = 1'b1;
        noise_n++;
      end else begin
        send_frame();
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes: %0d frames (%0d masked, %0d empty, %0d cut short), %0d noise bursts",
             bytes_sent, frames, masked_n, zero_len_n, cut_n, noise_n);
    $display("%0d restarts; %0d result words checked across a long sink stall and a full drain",
             restarts, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_stage.sv
rtl/core/websocket_frame_deframer.sv
rtl/core/wsd_checker.sv
verif/websocket_frame_deframer_checker.sv
verif/websocket_frame_deframer_tb.sv
